// ===== rtl/bloom_filter_insert_query_defines.svh =====
// assertion macros for the bloom filter checker
`ifndef BLOOM_FILTER_INSERT_QUERY_DEFINES_SVH
`define BLOOM_FILTER_INSERT_QUERY_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define BFIQ_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bfiq check failed");

// antecedent implies consequent in the next cycle
`define BFIQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bfiq check failed");

`endif

// ===== rtl/bfiq_pkg.sv =====
// constants and helper functions shared by the bloom filter files
package bfiq_pkg;

    // operation codes carried on kind and done_kind
    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_QUERY  = 2'd1;
    localparam logic [1:0] KIND_CLEAR  = 2'd2;
    localparam logic [1:0] KIND_NONE   = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_FILTER_BYTES  = 2'd0;
    localparam logic [1:0] CFG_INSERT_PROBES = 2'd1;
    localparam logic [1:0] CFG_QUERY_PROBES  = 2'd2;

    // configuration reset values
    localparam logic [10:0] FILTER_BYTES_RST  = 11'd1024;
    localparam logic [4:0]  INSERT_PROBES_RST = 5'd7;
    localparam logic [5:0]  QUERY_PROBES_RST  = 6'd6;
    localparam logic [10:0] FILTER_BYTES_MIN  = 11'd8;

    // hash constants
    localparam logic [31:0] HASH_MUL  = 32'hc6a4a793;
    localparam logic [31:0] HASH_SEED = 32'hbc9f1d34;
    localparam int          HASH_ROT  = 17;
    localparam int          MIX_FULL  = 16;
    localparam int          MIX_TAIL  = 24;

    // query probe counts above this always report a match
    localparam logic [5:0] QUERY_ALWAYS = 6'd30;

    // sign-extend one byte to a word
    function automatic logic [31:0] sext8(input logic [7:0] b);
        return {{24{b[7]}}, b};
    endfunction

    // value added to the hash for one word: full word or sign-extended tail bytes
    function automatic logic [31:0] word_addend(input logic [31:0] w, input logic [2:0] nb);
        logic [31:0] sum;
        sum = 32'd0;
        if (nb >= 3'd4)
        begin
            sum = w;
        end
        else if (nb != 3'd0)
        begin
            sum = sext8(w[7:0]);
            if (nb >= 3'd2)
            begin
                sum = sum + (sext8(w[15:8]) << 8);
            end
            if (nb >= 3'd3)
            begin
                sum = sum + (sext8(w[23:16]) << 16);
            end
        end
        return sum;
    endfunction

endpackage

// ===== rtl/bloom_filter_insert_query.sv =====
// bloom filter top level: key hashing, double-hashing probes and bit store
//
// A key arrives as one word per start pulse; busy stays high while the word
// is worked on. A word is added to the hash, multiplied and mixed; a word
// that opens a key first has the key length multiplied in, all through the
// one shared 32x32 multiplier; a word with no bytes skips its own multiply.
// On the last word of an insert or query each probe takes a bit-serial
// remainder of the hash by the bit count, one store read and one store
// update; a query that misses stops early. A clear sweeps all FILTER_BYTES
// bytes of the store one byte a cycle, then reports; the same sweep runs
// after reset, with busy high and no result. Each result shows on done for
// one cycle and cannot be held off; may_match is only ever 1 for a query.
// Configuration writes take effect at once and belong in idle time.
module bloom_filter_insert_query #(
    parameter int FILTER_BYTES = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  kind,
    input  logic [31:0] key_word,
    input  logic [2:0]  word_bytes,
    input  logic [15:0] key_length,
    input  logic        last,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [10:0] cfg_data,
    output logic        done,
    output logic        may_match,
    output logic [1:0]  done_kind
);

    localparam int AW = $clog2(FILTER_BYTES);
    localparam int NW = AW + 1;
    localparam int BW = AW + 4;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLR,
        S_INIT,
        S_SEED,
        S_ADD,
        S_MUL,
        S_MIX,
        S_END,
        S_MOD,
        S_RD,
        S_UPD
    } state_t;

    state_t      state_reg;
    logic [10:0] filter_bytes_reg;
    logic [4:0]  insert_probes_reg;
    logic [5:0]  query_probes_reg;

    logic        in_key_reg;
    logic [31:0] hash_acc_reg;
    logic [1:0]  kind_reg;
    logic [31:0] addend_reg;
    logic [15:0] klen_reg;
    logic        tail_reg;
    logic        empty_reg;
    logic        last_reg;
    logic [31:0] h_reg;
    logic [31:0] prod_reg;
    logic [31:0] delta_reg;
    logic [31:0] div_sh_reg;
    logic [BW-1:0] rem_reg;
    logic [BW-1:0] bits_reg;
    logic [4:0]  bitcnt_reg;
    logic [5:0]  cnt_reg;
    logic [5:0]  probes_reg;
    logic [AW-1:0] sweep_reg;
    logic        clr_report_reg;
    logic        done_reg;
    logic        may_match_reg;
    logic [1:0]  done_kind_reg;

    logic [2:0]    nb_clamp;
    logic [NW-1:0] nbytes;
    logic [BW-1:0] bits_c;
    logic [31:0]   mul_a;
    logic [31:0]   prod_c;
    logic [BW:0]   rem_sh;
    logic [BW:0]   rem_sub;
    logic [BW-1:0] rem_next;
    logic [31:0]   h_next;
    logic [5:0]    cnt_next;
    logic [5:0]    probe_sel;
    logic [AW-1:0] byte_idx;
    logic [7:0]    bit_mask;
    logic          bit_hit;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    logic [7:0]    ram_rdata;

    // word byte count, oversized counts act as a full word
    assign nb_clamp = (word_bytes > 3'd4) ? 3'd4 : word_bytes;

    // store size clamped to the implemented range, in bits
    always_comb
    begin
        if (filter_bytes_reg < bfiq_pkg::FILTER_BYTES_MIN)
        begin
            nbytes = NW'(bfiq_pkg::FILTER_BYTES_MIN);
        end
        else if ({21'd0, filter_bytes_reg} > 32'(FILTER_BYTES))
        begin
            nbytes = NW'(FILTER_BYTES);
        end
        else
        begin
            nbytes = NW'(filter_bytes_reg);
        end
    end
    assign bits_c = {nbytes, 3'b000};

    // shared multiplier: key length at key start, else the running hash
    assign mul_a  = (state_reg == S_INIT) ? {16'd0, klen_reg} : h_reg;
    assign prod_c = mul_a * bfiq_pkg::HASH_MUL;

    // one restoring remainder step per cycle
    assign rem_sh   = {rem_reg, div_sh_reg[31]};
    assign rem_sub  = rem_sh - {1'b0, bits_reg};
    assign rem_next = rem_sub[BW] ? rem_sh[BW-1:0] : rem_sub[BW-1:0];

    // probe position within the store
    assign byte_idx = rem_reg[AW+2:3];
    assign bit_mask = 8'd1 << rem_reg[2:0];
    assign bit_hit  = ram_rdata[rem_reg[2:0]];
    assign h_next   = h_reg + delta_reg;
    assign cnt_next = cnt_reg + 6'd1;

    // probe count for the completed key
    assign probe_sel = (kind_reg == bfiq_pkg::KIND_INSERT) ? {1'b0, insert_probes_reg}
                                                          : query_probes_reg;

    // store write port: clearing sweep or probe bit set
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = byte_idx;
        ram_wdata = ram_rdata | bit_mask;
        if (state_reg == S_CLR)
        begin
            ram_we    = 1'b1;
            ram_waddr = sweep_reg;
            ram_wdata = 8'd0;
        end
        else if (state_reg == S_UPD && kind_reg == bfiq_pkg::KIND_INSERT)
        begin
            ram_we = 1'b1;
        end
    end

    bfiq_ram #(
        .WIDTH (8),
        .DEPTH (FILTER_BYTES)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (byte_idx),
        .rdata (ram_rdata)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_bytes_reg  <= bfiq_pkg::FILTER_BYTES_RST;
            insert_probes_reg <= bfiq_pkg::INSERT_PROBES_RST;
            query_probes_reg  <= bfiq_pkg::QUERY_PROBES_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                bfiq_pkg::CFG_FILTER_BYTES:  filter_bytes_reg  <= cfg_data;
                bfiq_pkg::CFG_INSERT_PROBES: insert_probes_reg <= cfg_data[4:0];
                bfiq_pkg::CFG_QUERY_PROBES:  query_probes_reg  <= cfg_data[5:0];
                default: ;
            endcase
        end
    end

    // sequencer with registered result outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLR;
            sweep_reg      <= '0;
            clr_report_reg <= 1'b0;
            in_key_reg     <= 1'b0;
            hash_acc_reg   <= 32'd0;
            done_reg       <= 1'b0;
            may_match_reg  <= 1'b0;
            done_kind_reg  <= bfiq_pkg::KIND_INSERT;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        kind_reg   <= kind;
                        addend_reg <= bfiq_pkg::word_addend(key_word, nb_clamp);
                        klen_reg   <= key_length;
                        tail_reg   <= (nb_clamp != 3'd4);
                        empty_reg  <= (nb_clamp == 3'd0);
                        last_reg   <= last;
                        if (kind == bfiq_pkg::KIND_CLEAR)
                        begin
                            sweep_reg      <= '0;
                            clr_report_reg <= 1'b1;
                            state_reg      <= S_CLR;
                        end
                        else if (kind != bfiq_pkg::KIND_NONE)
                        begin
                            if (!in_key_reg)
                            begin
                                state_reg <= S_INIT;
                            end
                            else if (nb_clamp == 3'd0)
                            begin
                                state_reg <= S_END;
                            end
                            else
                            begin
                                state_reg <= S_ADD;
                            end
                        end
                    end
                end
                S_CLR:
                begin
                    sweep_reg <= sweep_reg + AW'(1);
                    if (sweep_reg == AW'(FILTER_BYTES - 1))
                    begin
                        in_key_reg   <= 1'b0;
                        hash_acc_reg <= 32'd0;
                        if (clr_report_reg)
                        begin
                            done_reg      <= 1'b1;
                            may_match_reg <= 1'b0;
                            done_kind_reg <= bfiq_pkg::KIND_CLEAR;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                S_INIT:
                begin
                    prod_reg  <= prod_c;
                    state_reg <= S_SEED;
                end
                S_SEED:
                begin
                    hash_acc_reg <= bfiq_pkg::HASH_SEED ^ prod_reg;
                    state_reg    <= empty_reg ? S_END : S_ADD;
                end
                S_ADD:
                begin
                    h_reg     <= hash_acc_reg + addend_reg;
                    state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    prod_reg  <= prod_c;
                    state_reg <= S_MIX;
                end
                S_MIX:
                begin
                    if (tail_reg)
                    begin
                        hash_acc_reg <= prod_reg ^ (prod_reg >> bfiq_pkg::MIX_TAIL);
                    end
                    else
                    begin
                        hash_acc_reg <= prod_reg ^ (prod_reg >> bfiq_pkg::MIX_FULL);
                    end
                    state_reg <= S_END;
                end
                S_END:
                begin
                    in_key_reg <= !last_reg;
                    if (!last_reg)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else if ((kind_reg == bfiq_pkg::KIND_QUERY
                              && query_probes_reg > bfiq_pkg::QUERY_ALWAYS)
                             || probe_sel == 6'd0)
                    begin
                        done_reg      <= 1'b1;
                        may_match_reg <= (kind_reg == bfiq_pkg::KIND_QUERY);
                        done_kind_reg <= kind_reg;
                        state_reg     <= S_IDLE;
                    end
                    else
                    begin
                        h_reg      <= hash_acc_reg;
                        delta_reg  <= (hash_acc_reg >> bfiq_pkg::HASH_ROT)
                                      | (hash_acc_reg << (32 - bfiq_pkg::HASH_ROT));
                        div_sh_reg <= hash_acc_reg;
                        rem_reg    <= '0;
                        bitcnt_reg <= 5'd0;
                        bits_reg   <= bits_c;
                        cnt_reg    <= 6'd0;
                        probes_reg <= probe_sel;
                        state_reg  <= S_MOD;
                    end
                end
                S_MOD:
                begin
                    rem_reg    <= rem_next;
                    div_sh_reg <= div_sh_reg << 1;
                    bitcnt_reg <= bitcnt_reg + 5'd1;
                    if (bitcnt_reg == 5'd31)
                    begin
                        state_reg <= S_RD;
                    end
                end
                S_RD:
                begin
                    state_reg <= S_UPD;
                end
                S_UPD:
                begin
                    if (kind_reg == bfiq_pkg::KIND_QUERY && !bit_hit)
                    begin
                        done_reg      <= 1'b1;
                        may_match_reg <= 1'b0;
                        done_kind_reg <= kind_reg;
                        state_reg     <= S_IDLE;
                    end
                    else if (cnt_next == probes_reg)
                    begin
                        done_reg      <= 1'b1;
                        may_match_reg <= (kind_reg == bfiq_pkg::KIND_QUERY);
                        done_kind_reg <= kind_reg;
                        state_reg     <= S_IDLE;
                    end
                    else
                    begin
                        cnt_reg    <= cnt_next;
                        h_reg      <= h_next;
                        div_sh_reg <= h_next;
                        rem_reg    <= '0;
                        bitcnt_reg <= 5'd0;
                        state_reg  <= S_MOD;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy      = (state_reg != S_IDLE);
    assign done      = done_reg;
    assign may_match = may_match_reg;
    assign done_kind = done_kind_reg;

endmodule

// ===== rtl/bfiq_ram.sv =====
// generic simple dual-port ram with registered read
module bfiq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/bfiq_checker.sv =====
// port-level checks for the bloom filter, bound to the top level
`include "bloom_filter_insert_query_defines.svh"

module bfiq_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic [1:0]  kind,
    input logic        last,
    input logic        done,
    input logic        may_match,
    input logic [1:0]  done_kind
);

    // a result always carries a real operation code
    `BFIQ_ASSERT_SAME(a_done_kind_valid, done, done_kind != bfiq_pkg::KIND_NONE)

    // only a query can report a possible match
    `BFIQ_ASSERT_SAME(a_match_only_query, done && done_kind != bfiq_pkg::KIND_QUERY, !may_match)

    // the block is idle while a result is shown
    `BFIQ_ASSERT_SAME(a_done_idle, done, !busy)

    // a key word that is not the last one gives no result
    `BFIQ_ASSERT_NEXT(a_partial_silent,
        start && !busy && !last && (kind == bfiq_pkg::KIND_INSERT || kind == bfiq_pkg::KIND_QUERY),
        !done)

    // a clear keeps the block busy while it sweeps the store
    `BFIQ_ASSERT_NEXT(a_clear_busy, start && !busy && kind == bfiq_pkg::KIND_CLEAR, busy && !done)

endmodule

bind bloom_filter_insert_query bfiq_checker u_bfiq_checker (.*);

// ===== verif/tb_bloom_filter_insert_query.sv =====
// self-checking testbench for the bloom filter insert/query block
module tb_bloom_filter_insert_query;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STORE_BYTES   = 1024;
    localparam int SETTLE_CYCLES = 16;
    localparam int DRAIN_CYCLES  = 64;
    localparam int PHASES        = 12;
    localparam int PHASE_WORDS   = 60;
    localparam int POOL_KEYS     = 16;
    localparam int MAX_KEY_BYTES = 40;
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    // expected value typed into the table, or derived by the predictor
    localparam bit TYPED   = 1'b1;
    localparam bit DERIVED = 1'b0;

    typedef struct packed {
        logic       may_match;
        logic [1:0] done_kind;
    } outcome_t;

    typedef enum logic {ROW_WORD, ROW_CFG} row_op_t;

    typedef struct {
        row_op_t     op;
        logic [1:0]  kind;
        logic [31:0] word;
        logic [2:0]  nb;
        logic [15:0] klen;
        logic        lst;
        bit          typed;
        logic        typed_match;
        logic [1:0]  reg_idx;
        logic [10:0] reg_val;
    } stim_row_t;

    typedef enum int {
        FLAW_NONE,
        FLAW_WIDE_COUNT,
        FLAW_SHORT_MID,
        FLAW_SWAP_KIND,
        FLAW_STRAY_WORD,
        FLAW_ODD_LENGTH,
        FLAW_CLEAR_MID
    } flaw_t;

    typedef struct packed {
        logic [5:0]   len;
        logic [319:0] data;
    } key_t;

    logic        clk;
    logic        rst_n      = 1'b0;
    logic        start      = 1'b0;
    logic        busy;
    logic [1:0]  kind       = bfiq_pkg::KIND_INSERT;
    logic [31:0] key_word   = 32'h0;
    logic [2:0]  word_bytes = 3'd0;
    logic [15:0] key_length = 16'h0;
    logic        last       = 1'b0;
    logic        cfg_we     = 1'b0;
    logic [1:0]  cfg_index  = bfiq_pkg::CFG_FILTER_BYTES;
    logic [10:0] cfg_data   = 11'd0;
    logic        done;
    logic        may_match;
    logic [1:0]  done_kind;

    // shadow of the block state and its registers
    logic [7:0]  shadow_store [0:STORE_BYTES-1];
    logic [31:0] shadow_hash   = 32'h0;
    bit          shadow_in_key = 1'b0;
    logic [10:0] cur_filter_bytes  = bfiq_pkg::FILTER_BYTES_RST;
    logic [4:0]  cur_insert_probes = bfiq_pkg::INSERT_PROBES_RST;
    logic [5:0]  cur_query_probes  = bfiq_pkg::QUERY_PROBES_RST;

    outcome_t  expected_outcomes [$];
    stim_row_t directed_rows [$];
    key_t      key_pool [0:POOL_KEYS-1];
    int        pool_fill  = 0;
    int        pool_next  = 0;
    int        mismatches = 0;
    int        words_sent = 0;
    bit        gaps_on    = 1'b1;

    // fixed register settings of the first random phases
    logic [10:0] fb_plan [0:6] = '{11'd1024, 11'd8, 11'd1024, 11'd64, 11'd8, 11'd2047, 11'd3};
    logic [10:0] ip_plan [0:6] = '{11'd7, 11'd31, 11'd1, 11'd3, 11'd2, 11'd0, 11'd5};
    logic [10:0] qp_plan [0:6] = '{11'd6, 11'd30, 11'd1, 11'd5, 11'd63, 11'd2, 11'd4};

    bloom_filter_insert_query #(
        .FILTER_BYTES(STORE_BYTES)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .kind       (kind),
        .key_word   (key_word),
        .word_bytes (word_bytes),
        .key_length (key_length),
        .last       (last),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .done       (done),
        .may_match  (may_match),
        .done_kind  (done_kind)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // run limit
    initial
    begin
        #20_000_000;
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        foreach (shadow_store[i])
        begin
            shadow_store[i] = 8'h00;
        end
    end

    // fold one key word into the running hash
    function automatic logic [31:0] mix_word(input logic [31:0] h, input logic [31:0] w,
                                             input logic [2:0] nb);
        logic [2:0]  n;
        logic [31:0] acc;
        n = (nb > 3'd4) ? 3'd4 : nb;
        acc = h;
        if (n == 3'd4)
        begin
            acc = acc + w;
            acc = acc * bfiq_pkg::HASH_MUL;
            acc = acc ^ (acc >> bfiq_pkg::MIX_FULL);
        end
        else if (n != 3'd0)
        begin
            // tail bytes are sign-extended before they are added
            if (n >= 3'd3)
            begin
                acc = acc + {{8{w[23]}}, w[23:16], 16'h0000};
            end
            if (n >= 3'd2)
            begin
                acc = acc + {{16{w[15]}}, w[15:8], 8'h00};
            end
            acc = acc + {{24{w[7]}}, w[7:0]};
            acc = acc * bfiq_pkg::HASH_MUL;
            acc = acc ^ (acc >> bfiq_pkg::MIX_TAIL);
        end
        return acc;
    endfunction

    // double-hashing walk over the shadow store; sets bits or tests them
    function automatic bit walk_probes(input logic [31:0] seed_h, input int count,
                                       input bit set_bits);
        logic [31:0] h;
        logic [31:0] step;
        logic [31:0] span;
        logic [31:0] pos;
        logic [31:0] nbytes;
        int          idx;
        nbytes = {21'd0, cur_filter_bytes};
        if (nbytes < 32'(bfiq_pkg::FILTER_BYTES_MIN))
        begin
            nbytes = 32'(bfiq_pkg::FILTER_BYTES_MIN);
        end
        if (nbytes > STORE_BYTES)
        begin
            nbytes = STORE_BYTES;
        end
        span = nbytes << 3;
        h = seed_h;
        step = (h >> bfiq_pkg::HASH_ROT) | (h << (32 - bfiq_pkg::HASH_ROT));
        for (int j = 0; j < count; j++)
        begin
            pos = h % span;
            idx = int'(pos >> 3);
            if (idx >= STORE_BYTES)
            begin
                idx = STORE_BYTES - 1;
            end
            if (set_bits)
            begin
                shadow_store[idx][pos[2:0]] = 1'b1;
            end
            else if (!shadow_store[idx][pos[2:0]])
            begin
                return 1'b0;
            end
            h = h + step;
        end
        return 1'b1;
    endfunction

    // predicted outcome of one accepted input word
    function automatic void predict_outcome(input logic [1:0] k, input logic [31:0] w,
                                            input logic [2:0] nb, input logic [15:0] klen,
                                            input logic lst, output bit produces,
                                            output outcome_t res);
        logic [31:0] h;
        produces = 1'b0;
        res = '0;
        if (k == bfiq_pkg::KIND_NONE)
        begin
            return;
        end
        if (k == bfiq_pkg::KIND_CLEAR)
        begin
            foreach (shadow_store[i])
            begin
                shadow_store[i] = 8'h00;
            end
            shadow_hash = 32'h0;
            shadow_in_key = 1'b0;
            produces = 1'b1;
            res.done_kind = bfiq_pkg::KIND_CLEAR;
            return;
        end
        // a key opens with the seed mixed with its length
        if (!shadow_in_key)
        begin
            shadow_hash = bfiq_pkg::HASH_SEED ^ ({16'h0000, klen} * bfiq_pkg::HASH_MUL);
        end
        h = mix_word(shadow_hash, w, nb);
        shadow_hash = h;
        if (!lst)
        begin
            shadow_in_key = 1'b1;
            return;
        end
        shadow_in_key = 1'b0;
        produces = 1'b1;
        res.done_kind = k;
        if (k == bfiq_pkg::KIND_INSERT)
        begin
            void'(walk_probes(h, int'(cur_insert_probes), 1'b1));
        end
        else if (cur_query_probes > bfiq_pkg::QUERY_ALWAYS)
        begin
            res.may_match = 1'b1;
        end
        else
        begin
            res.may_match = walk_probes(h, int'(cur_query_probes), 1'b0);
        end
    endfunction

    function automatic stim_row_t word_row(input logic [1:0] k, input logic [31:0] w,
                                           input logic [2:0] nb, input logic [15:0] klen,
                                           input logic lst, input bit typed,
                                           input logic typed_match);
        stim_row_t r;
        r = '{op: ROW_WORD, kind: k, word: w, nb: nb, klen: klen, lst: lst, typed: typed,
              typed_match: typed_match, reg_idx: bfiq_pkg::CFG_FILTER_BYTES, reg_val: 11'd0};
        return r;
    endfunction

    function automatic stim_row_t reg_row(input logic [1:0] idx, input logic [10:0] val);
        stim_row_t r;
        r = '{op: ROW_CFG, kind: bfiq_pkg::KIND_NONE, word: 32'h0, nb: 3'd0, klen: 16'h0,
              lst: 1'b0, typed: DERIVED, typed_match: 1'b0, reg_idx: idx, reg_val: val};
        return r;
    endfunction

    // present one word on the command port and wait for it to be taken
    task automatic send_word(input logic [1:0] k, input logic [31:0] w, input logic [2:0] nb,
                             input logic [15:0] klen, input logic lst, input bit typed,
                             input logic typed_match);
        int       gap;
        bit       produces;
        outcome_t res;
        if (gaps_on && $urandom_range(0, 99) < 14)
        begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 12);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start      <= 1'b1;
        kind       <= k;
        key_word   <= w;
        word_bytes <= nb;
        key_length <= klen;
        last       <= lst;
        do
            @(posedge clk);
        while (busy);
        predict_outcome(k, w, nb, klen, lst, produces, res);
        if (produces)
        begin
            if (typed)
            begin
                res.may_match = typed_match;
                res.done_kind = k;
            end
            expected_outcomes.push_back(res);
        end
        if (k != bfiq_pkg::KIND_NONE)
        begin
            words_sent++;
        end
    endtask

    // drop start and wait until the block has nothing left to do
    task automatic settle();
        start <= 1'b0;
        while (expected_outcomes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [10:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            bfiq_pkg::CFG_FILTER_BYTES:  cur_filter_bytes = val;
            bfiq_pkg::CFG_INSERT_PROBES: cur_insert_probes = val[4:0];
            bfiq_pkg::CFG_QUERY_PROBES:  cur_query_probes = val[5:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    // one random key, mostly well formed, sometimes bent
    task automatic send_random_key();
        int           roll;
        int           len;
        int           nwords;
        int           spot;
        int           tail;
        flaw_t        flaw;
        logic [1:0]   op;
        logic [1:0]   lkind;
        logic [319:0] data;
        logic [15:0]  klen;
        logic [31:0]  w;
        logic [31:0]  keep;
        logic [2:0]   nb;
        key_t         pick;
        roll = $urandom_range(0, 99);
        if (roll < 4)
        begin
            send_word(bfiq_pkg::KIND_CLEAR, $urandom, 3'($urandom), 16'($urandom),
                      1'($urandom), DERIVED, 1'b0);
            return;
        end
        if (roll < 8)
        begin
            send_word(bfiq_pkg::KIND_NONE, $urandom, 3'($urandom), 16'($urandom),
                      1'($urandom), DERIVED, 1'b0);
            return;
        end
        op = ($urandom_range(0, 1) == 0) ? bfiq_pkg::KIND_INSERT : bfiq_pkg::KIND_QUERY;
        // queries often reuse an inserted key so that hits show up
        if (op == bfiq_pkg::KIND_QUERY && pool_fill > 0 && $urandom_range(0, 9) < 6)
        begin
            pick = key_pool[$urandom_range(0, pool_fill - 1)];
            len = int'(pick.len);
            data = pick.data;
        end
        else
        begin
            len = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 12)
                                               : $urandom_range(13, MAX_KEY_BYTES);
            for (int i = 0; i < 10; i++)
            begin
                data[32*i +: 32] = $urandom;
            end
        end
        if (op == bfiq_pkg::KIND_INSERT)
        begin
            key_pool[pool_next] = '{len: 6'(len), data: data};
            pool_next = (pool_next + 1) % POOL_KEYS;
            if (pool_fill < POOL_KEYS)
            begin
                pool_fill++;
            end
        end
        flaw = ($urandom_range(0, 99) < 12) ? flaw_t'($urandom_range(1, 6)) : FLAW_NONE;
        klen = (flaw == FLAW_ODD_LENGTH) ? 16'($urandom) : 16'(len);
        nwords = (len == 0) ? 1 : (len + 3) / 4;
        spot = $urandom_range(0, nwords - 1);
        for (int i = 0; i < nwords; i++)
        begin
            tail = len - 4 * i;
            if (tail > 4)
            begin
                tail = 4;
            end
            nb = 3'(tail);
            w = data[32*i +: 32];
            // junk above the valid bytes must not matter
            if (tail < 4)
            begin
                keep = (32'h1 << (8 * tail)) - 32'h1;
                w = (w & keep) | ($urandom & ~keep);
            end
            if (i == spot)
            begin
                case (flaw)
                    FLAW_WIDE_COUNT:
                        if (nb == 3'd4)
                        begin
                            nb = 3'($urandom_range(5, 7));
                        end
                    FLAW_SHORT_MID:
                        if (i != nwords - 1)
                        begin
                            nb = 3'($urandom_range(0, 3));
                        end
                    FLAW_STRAY_WORD:
                        send_word(bfiq_pkg::KIND_NONE, $urandom, 3'($urandom), 16'($urandom),
                                  1'($urandom), DERIVED, 1'b0);
                    FLAW_CLEAR_MID:
                        send_word(bfiq_pkg::KIND_CLEAR, $urandom, 3'($urandom), 16'($urandom),
                                  1'($urandom), DERIVED, 1'b0);
                    default: ;
                endcase
            end
            lkind = op;
            if (flaw == FLAW_SWAP_KIND && i == nwords - 1)
            begin
                lkind = (op == bfiq_pkg::KIND_INSERT) ? bfiq_pkg::KIND_QUERY
                                                      : bfiq_pkg::KIND_INSERT;
            end
            // key length only counts on the opening word
            send_word(lkind, w, nb, (i == 0) ? klen : 16'($urandom), i == nwords - 1,
                      DERIVED, 1'b0);
        end
    endtask

    // result checker
    always @(posedge clk)
    begin
        outcome_t want;
        if (rst_n && done)
        begin
            if (expected_outcomes.size() == 0)
            begin
                $display("%0t: result word with none expected: may_match %0b done_kind %0d",
                         $time, may_match, done_kind);
                mismatches++;
            end
            else
            begin
                want = expected_outcomes.pop_front();
                if (done_kind !== want.done_kind)
                begin
                    $display("%0t: done_kind expected %0d, got %0d",
                             $time, want.done_kind, done_kind);
                    mismatches++;
                end
                if (may_match !== want.may_match)
                begin
                    $display("%0t: may_match expected %0b, got %0b",
                             $time, want.may_match, may_match);
                    mismatches++;
                end
            end
        end
    end

    // stimulus
    initial
    begin
        int target;

        // empty key on an empty store, then the same key inserted and found
        directed_rows.push_back(word_row(bfiq_pkg::KIND_QUERY, 32'h0, 3'd0, 16'd0, 1'b1,
                                         TYPED, 1'b0));
        directed_rows.push_back(word_row(bfiq_pkg::KIND_INSERT, 32'h0, 3'd0, 16'd0, 1'b1,
                                         TYPED, 1'b0));
        directed_rows.push_back(word_row(bfiq_pkg::KIND_QUERY, 32'h0, 3'd0, 16'd0, 1'b1,
                                         DERIVED, 1'b0));
        // all-ones word, longest length, negative tail bytes
        directed_rows.push_back(word_row(bfiq_pkg::KIND_INSERT, 32'hffffffff, 3'd4, 16'hffff,
                                         1'b0, DERIVED, 1'b0));
        directed_rows.push_back(word_row(bfiq_pkg::KIND_INSERT, 32'h00808080, 3'd3, 16'd0,
                                         1'b1, TYPED, 1'b0));
        directed_rows.push_back(word_row(bfiq_pkg::KIND_QUERY, 32'hffffffff, 3'd4, 16'hffff,
                                         1'b0, DERIVED, 1'b0));
        directed_rows.push_back(word_row(bfiq_pkg::KIND_QUERY, 32'h00808080, 3'd3, 16'd0,
                                         1'b1, DERIVED, 1'b0));
        // oversized byte count
        directed_rows.push_back(word_row(bfiq_pkg::KIND_QUERY, 32'hdeadbeef, 3'd7, 16'd4,
                                         1'b1, DERIVED, 1'b0));
        // short word ahead of the last, with an ignored kind in between
        directed_rows.push_back(word_row(bfiq_pkg::KIND_INSERT, 32'h0000007f, 3'd1, 16'd5,
                                         1'b0, DERIVED, 1'b0));
        directed_rows.push_back(word_row(bfiq_pkg::KIND_NONE, 32'h12345678, 3'd4, 16'd0,
                                         1'b1, DERIVED, 1'b0));
        directed_rows.push_back(word_row(bfiq_pkg::KIND_INSERT, 32'h12345678, 3'd4, 16'd0,
                                         1'b1, TYPED, 1'b0));
        // kinds mixed within one key: the last word wins
        directed_rows.push_back(word_row(bfiq_pkg::KIND_QUERY, 32'haaaa55ff, 3'd4, 16'd6,
                                         1'b0, DERIVED, 1'b0));
        directed_rows.push_back(word_row(bfiq_pkg::KIND_INSERT, 32'hffff80ff, 3'd2, 16'd0,
                                         1'b1, TYPED, 1'b0));
        // clear drops a partial key, then the store reads empty
        directed_rows.push_back(word_row(bfiq_pkg::KIND_QUERY, 32'h0, 3'd4, 16'd9, 1'b0,
                                         DERIVED, 1'b0));
        directed_rows.push_back(word_row(bfiq_pkg::KIND_CLEAR, 32'h0, 3'd0, 16'd0, 1'b0,
                                         TYPED, 1'b0));
        directed_rows.push_back(word_row(bfiq_pkg::KIND_QUERY, 32'hffffffff, 3'd4, 16'hffff,
                                         1'b0, DERIVED, 1'b0));
        directed_rows.push_back(word_row(bfiq_pkg::KIND_QUERY, 32'h00808080, 3'd3, 16'd0,
                                         1'b1, TYPED, 1'b0));
        // query probe counts above the always-match limit
        directed_rows.push_back(reg_row(bfiq_pkg::CFG_QUERY_PROBES, 11'd31));
        directed_rows.push_back(word_row(bfiq_pkg::KIND_QUERY, 32'h13579bdf, 3'd4, 16'd4,
                                         1'b1, TYPED, 1'b1));
        directed_rows.push_back(reg_row(bfiq_pkg::CFG_QUERY_PROBES, 11'h7ff));
        directed_rows.push_back(word_row(bfiq_pkg::KIND_QUERY, 32'h0, 3'd0, 16'd0, 1'b1,
                                         TYPED, 1'b1));
        // zero query probes always match, zero insert probes set nothing
        directed_rows.push_back(reg_row(bfiq_pkg::CFG_QUERY_PROBES, 11'd0));
        directed_rows.push_back(word_row(bfiq_pkg::KIND_QUERY, 32'h2468ace0, 3'd4, 16'd4,
                                         1'b1, TYPED, 1'b1));
        directed_rows.push_back(reg_row(bfiq_pkg::CFG_INSERT_PROBES, 11'd0));
        directed_rows.push_back(word_row(bfiq_pkg::KIND_INSERT, 32'h0, 3'd0, 16'd0, 1'b1,
                                         TYPED, 1'b0));
        // filter size below range, most probes
        directed_rows.push_back(reg_row(bfiq_pkg::CFG_QUERY_PROBES, 11'd30));
        directed_rows.push_back(reg_row(bfiq_pkg::CFG_FILTER_BYTES, 11'd0));
        directed_rows.push_back(reg_row(bfiq_pkg::CFG_INSERT_PROBES, 11'h7ff));
        directed_rows.push_back(word_row(bfiq_pkg::KIND_INSERT, 32'h76543210, 3'd4, 16'd4,
                                         1'b1, DERIVED, 1'b0));
        directed_rows.push_back(word_row(bfiq_pkg::KIND_QUERY, 32'h76543210, 3'd4, 16'd4,
                                         1'b1, DERIVED, 1'b0));
        // filter size above range, write to an unused index
        directed_rows.push_back(reg_row(bfiq_pkg::CFG_FILTER_BYTES, 11'h7ff));
        directed_rows.push_back(reg_row(CFG_UNUSED, 11'd5));
        directed_rows.push_back(word_row(bfiq_pkg::KIND_QUERY, 32'h0, 3'd0, 16'd0, 1'b1,
                                         DERIVED, 1'b0));
        directed_rows.push_back(word_row(bfiq_pkg::KIND_CLEAR, 32'hffffffff, 3'd7, 16'hffff,
                                         1'b1, TYPED, 1'b0));

        // reset, then wait out the store sweep
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        settle();

        // directed table
        foreach (directed_rows[i])
        begin
            if (directed_rows[i].op == ROW_CFG)
            begin
                settle();
                write_reg(directed_rows[i].reg_idx, directed_rows[i].reg_val);
            end
            else
            begin
                send_word(directed_rows[i].kind, directed_rows[i].word, directed_rows[i].nb,
                          directed_rows[i].klen, directed_rows[i].lst, directed_rows[i].typed,
                          directed_rows[i].typed_match);
            end
        end

        // random phases, each under its own register setting
        for (int p = 0; p < PHASES; p++)
        begin
            settle();
            if (p < 7)
            begin
                write_reg(bfiq_pkg::CFG_FILTER_BYTES, fb_plan[p]);
                write_reg(bfiq_pkg::CFG_INSERT_PROBES, ip_plan[p]);
                write_reg(bfiq_pkg::CFG_QUERY_PROBES, qp_plan[p]);
            end
            else
            begin
                write_reg(bfiq_pkg::CFG_FILTER_BYTES, ($urandom_range(0, 3) == 0) ?
                          11'($urandom_range(8, 64)) : 11'($urandom));
                write_reg(bfiq_pkg::CFG_INSERT_PROBES, 11'($urandom));
                write_reg(bfiq_pkg::CFG_QUERY_PROBES, 11'($urandom));
            end
            // one phase runs back to back with no gaps
            gaps_on = (p != 3);
            target = words_sent + PHASE_WORDS;
            while (words_sent < target)
                send_random_key();
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && expected_outcomes.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
